// ===== src/dpt_pkg.sv =====
// Package for the drum pad peak trigger.
// Holds the field widths, the register index codes, the sequencer state type
// and the control struct that passes between the sequencer and the peak unit.
`default_nettype none

package dpt_pkg;

    // Field widths.
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int LOCK_W   = 16;
    localparam int NOTE_W   = 7;
    localparam int VEL_W    = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Input modes.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_NUMBER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_VELOCITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FIXED_VEL  = 3'd4;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    // Control of the shared peak compare unit.
    typedef struct packed {
        logic clear;
        logic en;
    } peak_ctl_t;

endpackage : dpt_pkg

`default_nettype wire

// ===== src/dpt_if.sv =====
// Valid/ready channel interfaces for the drum pad peak trigger.
// Depends on dpt_pkg for the field widths.
`default_nettype none

interface dpt_in_if
    import dpt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                mode;
    logic [SAMPLE_W-1:0] sample;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, output mode, output sample, output now_ms, input ready);
    modport sink   (input valid, input mode, input sample, input now_ms, output ready);
endinterface : dpt_in_if

interface dpt_out_if
    import dpt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [NOTE_W-1:0] note_out;
    logic [VEL_W-1:0]  velocity_out;

    modport source (output valid, output hit, output note_out, output velocity_out,
                    input ready);
    modport sink   (input valid, input hit, input note_out, input velocity_out,
                    output ready);
endinterface : dpt_out_if

`default_nettype wire

// ===== src/drum_pad_peak_trigger_top.sv =====
// Top level of the drum pad peak trigger: sequencer, registers, ring RAM.
// Depends on dpt_pkg, dpt_if, dpt_ram and dpt_peak_unit.
//
//   Channel  Dir  Handshake      Payload
//   in_ch    in   valid/ready    mode, sample, now_ms
//   out_ch   out  valid/ready    hit, note_out, velocity_out
//   cfg      in   cfg_we         cfg_index, cfg_wdata
//
// A sample transfer writes the reading to the ring RAM.
// A query holds the input closed while the sequencer reads every ring entry
// in S_SCAN, takes in the last read in S_DRAIN and decides in S_DECIDE. The
// result and the input ready both appear at the same clock edge.
// Reset clears the configuration and control registers, the ring valid bits, the
// write index and the time of the last hit; an entry never written reads as zero.
// A finished result waits in the output register; a new query stalls in its
// last step only while an earlier result has not been taken.
`default_nettype none

module drum_pad_peak_trigger_top
    import dpt_pkg::*;
#(
    parameter int RING_DEPTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dpt_in_if.sink                     in_ch,
    dpt_out_if.source                  out_ch,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    // Configuration registers.
    logic [SAMPLE_W-1:0] threshold_reg;
    logic [LOCK_W-1:0]   lockout_reg;
    logic [NOTE_W-1:0]   note_reg;
    logic [NOTE_W-1:0]   fixed_vel_reg;
    logic                use_fixed_reg;

    // Control and state.
    state_t              state_reg, state_next;
    logic [AW-1:0]       wr_idx_reg, wr_idx_next;
    logic [AW-1:0]       scan_idx_reg, scan_idx_next;
    logic [RING_DEPTH-1:0] valid_reg, valid_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                rd_bit_reg;
    logic [TIME_W-1:0]   last_hit_reg, last_hit_next;
    logic [TIME_W-1:0]   now_reg;

    // Output register.
    logic                out_valid_reg, out_valid_next;
    logic                hit_reg;
    logic [NOTE_W-1:0]   note_out_reg;
    logic [VEL_W-1:0]    vel_out_reg;

    // Internal nets.
    logic                in_xfer;
    logic                smp_we;
    logic [SAMPLE_W-1:0] smp_kept;
    logic                issue_rd;
    logic                load_out;
    logic                locked;
    logic                is_hit;
    logic [TIME_W-1:0]   elapsed;
    logic [SAMPLE_W-1:0] ram_rdata;
    logic [SAMPLE_W-1:0] scan_data;
    logic [SAMPLE_W-1:0] peak;
    peak_ctl_t           peak_ctl;

    assign in_xfer = in_ch.valid && in_ch.ready;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            lockout_reg   <= '0;
            note_reg      <= '0;
            fixed_vel_reg <= '0;
            use_fixed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HIT_THRESHOLD:  threshold_reg <= cfg_wdata[SAMPLE_W-1:0];
                CFG_LOCKOUT_MS:     lockout_reg   <= cfg_wdata[LOCK_W-1:0];
                CFG_NOTE_NUMBER:    note_reg      <= cfg_wdata[NOTE_W-1:0];
                CFG_FIXED_VELOCITY: fixed_vel_reg <= cfg_wdata[NOTE_W-1:0];
                CFG_USE_FIXED_VEL:  use_fixed_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    // Sample path: readings below the threshold are stored as zero.
    assign smp_kept = (in_ch.sample < threshold_reg) ? '0 : in_ch.sample;
    assign smp_we   = in_xfer && (in_ch.mode == MODE_SAMPLE);

    // Lockout test and hit decision on the final peak.
    assign elapsed = now_reg - last_hit_reg;
    assign locked  = (elapsed < {{(TIME_W-LOCK_W){1'b0}}, lockout_reg});
    assign is_hit  = !locked && (peak >= threshold_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && (in_ch.mode == MODE_QUERY))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        in_ch.ready    = 1'b0;
        issue_rd       = 1'b0;
        load_out       = 1'b0;
        peak_ctl.clear = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready    = 1'b1;
                peak_ctl.clear = 1'b1;
            end
            S_SCAN:
            begin
                issue_rd = 1'b1;
            end
            S_DRAIN:
            begin
            end
            S_DECIDE:
            begin
                load_out = !out_valid_reg || out_ch.ready;
            end
            default:
            begin
            end
        endcase
        peak_ctl.en = rd_vld_reg;
    end

    // Counters, valid bits and the time of the last hit.
    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        valid_next    = valid_reg;
        scan_idx_next = scan_idx_reg;
        last_hit_next = last_hit_reg;
        rd_vld_next   = issue_rd;
        if (smp_we)
        begin
            valid_next[wr_idx_reg] = 1'b1;
            wr_idx_next = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
        end
        if (issue_rd)
        begin
            scan_idx_next = (scan_idx_reg == LAST_IDX) ? '0 : scan_idx_reg + 1'b1;
        end
        if (load_out && is_hit)
        begin
            last_hit_next = now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            wr_idx_reg   <= '0;
            scan_idx_reg <= '0;
            valid_reg    <= '0;
            rd_vld_reg   <= 1'b0;
            last_hit_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            wr_idx_reg   <= wr_idx_next;
            scan_idx_reg <= scan_idx_next;
            valid_reg    <= valid_next;
            rd_vld_reg   <= rd_vld_next;
            last_hit_reg <= last_hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: query time, valid bit of the entry read, result.
    always_ff @(posedge clk)
    begin
        rd_bit_reg <= valid_reg[scan_idx_reg];
        if (in_xfer)
        begin
            now_reg <= in_ch.now_ms;
        end
        if (load_out)
        begin
            hit_reg <= is_hit;
            if (locked)
            begin
                note_out_reg <= '0;
                vel_out_reg  <= '0;
            end
            else if (is_hit)
            begin
                note_out_reg <= note_reg;
                vel_out_reg  <= use_fixed_reg ? {{(VEL_W-NOTE_W){1'b0}}, fixed_vel_reg} : peak;
            end
            else
            begin
                note_out_reg <= '0;
                vel_out_reg  <= peak;
            end
        end
    end

    // Output valid: set on a new result, cleared when it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.hit          = hit_reg;
    assign out_ch.note_out     = note_out_reg;
    assign out_ch.velocity_out = vel_out_reg;

    // Ring storage.
    dpt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (smp_we),
        .waddr (wr_idx_reg),
        .wdata (smp_kept),
        .raddr (scan_idx_reg),
        .rdata (ram_rdata)
    );

    // An entry never written reads as zero.
    assign scan_data = rd_bit_reg ? ram_rdata : '0;

    dpt_peak_unit u_peak (
        .clk  (clk),
        .ctl  (peak_ctl),
        .din  (scan_data),
        .peak (peak)
    );
endmodule : drum_pad_peak_trigger_top

`default_nettype wire

// ===== src/dpt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module dpt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule : dpt_ram

`default_nettype wire

// ===== src/dpt_peak_unit.sv =====
// Shared compare unit that keeps the running maximum of the ring entries.
// Depends on dpt_pkg for the control struct and the sample width.
`default_nettype none

module dpt_peak_unit
    import dpt_pkg::*;
(
    input  wire logic                clk,
    input  wire peak_ctl_t           ctl,
    input  wire logic [SAMPLE_W-1:0] din,
    output logic      [SAMPLE_W-1:0] peak
);
    logic [SAMPLE_W-1:0] peak_reg;
    logic [SAMPLE_W-1:0] peak_next;

    // One compare per cycle against the stored maximum.
    always_comb
    begin
        peak_next = peak_reg;
        if (ctl.clear)
        begin
            peak_next = '0;
        end
        else if (ctl.en && (din > peak_reg))
        begin
            peak_next = din;
        end
    end

    always_ff @(posedge clk)
    begin
        peak_reg <= peak_next;
    end

    assign peak = peak_reg;
endmodule : dpt_peak_unit

`default_nettype wire

// ===== src/dpt_checker.sv =====
// Port-level checker for the drum pad peak trigger, bound to the top level.
// Depends on dpt_pkg for the field widths and the mode codes.
`default_nettype none

module dpt_checker
    import dpt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              in_mode,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              out_hit,
    input wire logic [NOTE_W-1:0] out_note,
    input wire logic [VEL_W-1:0]  out_vel
);
    // A waiting result holds its payload until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_hit)
            && $stable(out_note) && $stable(out_vel))
        else $error("result changed while stalled");

    // A result without a hit never carries a note.
    a_no_hit_note: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |-> out_note == '0)
        else $error("note reported without a hit");

    // A query keeps the input closed while the ring is scanned.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_QUERY) |=> !in_ready)
        else $error("input taken during a scan");

    // A sample transfer never produces a result.
    a_sample_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_mode == MODE_SAMPLE) && !out_valid |=> !out_valid)
        else $error("result after a sample");
endmodule : dpt_checker

bind drum_pad_peak_trigger_top dpt_checker u_dpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_hit   (out_ch.hit),
    .out_note  (out_ch.note_out),
    .out_vel   (out_ch.velocity_out)
);

`default_nettype wire
